[src/rgb_box_blur_3x3_unit_macros.svh]
// ----------------------------------------------------------------------------
// RGB box blur 3x3 unit: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_3X3_UNIT_MACROS_SVH
`define RGB_BOX_BLUR_3X3_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define RBB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define RBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// RGB box blur package
// Shared widths, constants, register codes and payload types.
// ----------------------------------------------------------------------------
package rbb_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int KERNEL_SIZE   = 3;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int ROW_W     = 12;
	localparam int CH_W      = 8;
	localparam int SUM_W     = 12;
	localparam int MUL_W     = 16;
	localparam int PROD_W    = SUM_W + MUL_W;

	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	// floor(sum / 9) == (sum * 58255) >> 19 for every sum 0..2295
	localparam logic [MUL_W-1:0] RECIP_NINE_MUL = 16'd58255;
	localparam int RECIP_NINE_SHIFT = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
	} line_pair_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sums_t;

endpackage

[src/rgb_box_blur_3x3_unit.sv]
// ----------------------------------------------------------------------------
// RGB box blur 3x3 unit
// Streaming 3x3 mean filter over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Feed the pixels of a frame in raster order, one transfer per pixel; the
// unit takes one pixel every clock as long as the output side keeps up, and
// a finished result may wait in the output register while the next pixel is
// taken. For each interior pixel it delivers the per-channel floor of the
// 3x3 mean once the lower-right neighbour has come in; border pixels give no
// result. The result then passes stage 1, stage 2 and the output register.
// The rate is set by the line memory, which serves one read and one write
// per clock: each pixel reads its column's two stored rows and writes them
// back shifted down one row the following clock. frame_width and
// frame_height are saturated to 3..MAX_WIDTH and 3..4096; write them only
// while the unit is idle. The line memory needs no clearing after reset,
// since data read before the first two rows are written feeds only border
// pixels, which give no result. frame_last marks the last interior pixel
// of a frame; the counters then wrap to start the next frame.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_unit
	import rbb_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CH_W-1:0]      red_in,
	input  logic [CH_W-1:0]      green_in,
	input  logic [CH_W-1:0]      blue_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      red_out,
	output logic [CH_W-1:0]      green_out,
	output logic [CH_W-1:0]      blue_out,
	output logic                 frame_last
);

	`include "rgb_box_blur_3x3_unit_macros.svh"

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WLAST_RST = ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1;
	localparam int EDGE      = KERNEL_SIZE - 1;

	// Configuration, kept as last column / last row index
	logic [CW-1:0]    wlast_q;
	logic [ROW_W-1:0] hlast_q;
	logic [CW-1:0]    wlast_nx;
	logic [ROW_W-1:0] hlast_nx;

	always_comb begin
		if (32'(wr_data) < 32'(KERNEL_SIZE)) begin
			wlast_nx = CW'(EDGE);
		end else if (32'(wr_data) > 32'(MAX_WIDTH)) begin
			wlast_nx = CW'(MAX_WIDTH - 1);
		end else begin
			wlast_nx = CW'(wr_data - CFG_W'(1));
		end
		if (32'(wr_data) < 32'(KERNEL_SIZE)) begin
			hlast_nx = ROW_W'(EDGE);
		end else if (32'(wr_data) > 32'(MAX_HEIGHT)) begin
			hlast_nx = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hlast_nx = ROW_W'(wr_data - CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CW'(WLAST_RST);
			hlast_q <= ROW_W'(HEIGHT_RST - 1);
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_FRAME_WIDTH: begin
					wlast_q <= wlast_nx;
				end
				REG_FRAME_HEIGHT: begin
					hlast_q <= hlast_nx;
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake and stage advance
	logic accept;
	logic s1_valid_q, s1_go, s1_free;
	logic s2_valid_q, s2_ld, s2_free;
	logic out_valid_q, out_adv, out_ld;
	logic emit_s1, last_s1, last_s2, frame_last_q;
	logic wr_pend_q;

	assign out_adv = !out_valid_q || !out_stall;
	assign out_ld  = s2_valid_q && out_adv;
	assign s2_free = !s2_valid_q || out_adv;
	// drop border pixels at stage 1: they only update window and line memory
	assign s1_go   = s1_valid_q && (!emit_s1 || s2_free);
	assign s1_free = !s1_valid_q || s1_go;
	assign s2_ld   = s1_go && emit_s1;
	assign accept  = in_valid && s1_free;
	assign in_stall = !s1_free;

	// Position counters
	logic [CW-1:0]    col_q, col_s1;
	logic [ROW_W-1:0] row_q;
	logic             last_col, last_row, emit_nx;

	assign last_col = col_q >= wlast_q;
	assign last_row = row_q >= hlast_q;
	assign emit_nx  = (32'(row_q) >= 32'(EDGE)) && (32'(col_q) >= 32'(EDGE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			wr_pend_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			s1_valid_q  <= accept || (s1_valid_q && !s1_go);
			s2_valid_q  <= s2_ld || (s2_valid_q && !out_adv);
			out_valid_q <= out_ld || (out_valid_q && out_stall);
			// write back the column the clock after its read
			wr_pend_q   <= accept;
		end
	end

	// Stage 1 payload: pixel, column, flags
	pix_t px_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= '{r: red_in, g: green_in, b: blue_in};
			col_s1  <= col_q;
			emit_s1 <= emit_nx;
			last_s1 <= last_col && last_row;
		end
		if (s2_ld) begin
			last_s2 <= last_s1;
		end
		if (out_ld) begin
			frame_last_q <= last_s2;
		end
	end

	// Line memory read-modify-write. The write of a pixel's column lands the
	// clock after its read, and consecutive pixels never share a column, so
	// a later read always sees the updated entry.
	line_pair_t rd_pair;
	line_pair_t wr_pair;

	assign wr_pair = '{top: rd_pair.mid, mid: px_s1};

	rbb_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_pair),
		.wr_en   (wr_pend_q),
		.wr_addr (col_s1),
		.wr_data (wr_pair)
	);

	// Window and nine-sample sums, advance with stage 1
	sums_t sums;

	rbb_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_go),
		.top      (rd_pair.top),
		.mid      (rd_pair.mid),
		.px       (px_s1),
		.sums     (sums)
	);

	// Divide by nine and output register
	rbb_mean9 u_mean9 (
		.clk    (clk),
		.ld_s2  (s2_ld),
		.sums   (sums),
		.ld_out (out_ld),
		.red    (red_out),
		.green  (green_out),
		.blue   (blue_out)
	);

	assign out_valid  = out_valid_q;
	assign frame_last = frame_last_q;

	// Checks
	`RBB_ASSERT_SAME(a_no_rw_clash, wr_pend_q && accept, col_s1 != col_q, "line memory read and write hit the same column")
	`RBB_ASSERT_NEXT(a_frame_wrap, accept && last_col && last_row, col_q == '0 && row_q == '0, "counters did not wrap at end of frame")
	`RBB_ASSERT_SAME(a_out_from_s2, $rose(out_valid_q), $past(s2_valid_q), "result appeared without a stage 2 item")

endmodule

[src/rbb_line_mem.sv]
// ----------------------------------------------------------------------------
// RGB box blur line memory
// Two stored rows per column in one synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module rbb_line_mem
	import rbb_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output line_pair_t    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  line_pair_t    wr_data
);

	line_pair_t mem [DEPTH];
	line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/rbb_window.sv]
// ----------------------------------------------------------------------------
// RGB box blur window
// Two left-hand columns of the 3x3 window and the per-channel nine-sample sums.
// ----------------------------------------------------------------------------
module rbb_window
	import rbb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  pix_t  top,
	input  pix_t  mid,
	input  pix_t  px,
	output sums_t sums
);

	// index 0..2: two columns left (top, mid, bottom); 3..5: one column left
	pix_t win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift_en) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px;
		end
	end

	always_comb begin
		sums.r = SUM_W'(top.r) + SUM_W'(mid.r) + SUM_W'(px.r);
		sums.g = SUM_W'(top.g) + SUM_W'(mid.g) + SUM_W'(px.g);
		sums.b = SUM_W'(top.b) + SUM_W'(mid.b) + SUM_W'(px.b);
		for (int i = 0; i < 6; i++) begin
			sums.r = sums.r + SUM_W'(win_q[i].r);
			sums.g = sums.g + SUM_W'(win_q[i].g);
			sums.b = sums.b + SUM_W'(win_q[i].b);
		end
	end

endmodule

[src/rbb_mean9.sv]
// ----------------------------------------------------------------------------
// RGB box blur divide by nine
// Registered sums, reciprocal multiply, registered 8-bit means.
// ----------------------------------------------------------------------------
module rbb_mean9
	import rbb_pkg::*;
(
	input  logic            clk,
	input  logic            ld_s2,
	input  sums_t           sums,
	input  logic            ld_out,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue
);

	sums_t             sums_s2;
	logic [PROD_W-1:0] prod_r, prod_g, prod_b;
	logic [CH_W-1:0]   red_q, green_q, blue_q;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			sums_s2 <= sums;
		end
	end

	assign prod_r = PROD_W'(sums_s2.r) * PROD_W'(RECIP_NINE_MUL);
	assign prod_g = PROD_W'(sums_s2.g) * PROD_W'(RECIP_NINE_MUL);
	assign prod_b = PROD_W'(sums_s2.b) * PROD_W'(RECIP_NINE_MUL);

	always_ff @(posedge clk) begin
		if (ld_out) begin
			red_q   <= prod_r[RECIP_NINE_SHIFT +: CH_W];
			green_q <= prod_g[RECIP_NINE_SHIFT +: CH_W];
			blue_q  <= prod_b[RECIP_NINE_SHIFT +: CH_W];
		end
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule
